[hdl/a85_pkg.sv]
// Shared types and constants for the ASCII85 stream encoder.
`timescale 1ns / 1ps

package a85_pkg;

    localparam int DIG_W  = 7;   // one base-85 digit
    localparam int NDIG_W = 3;   // digit count 0..5
    localparam int GROUP_DIGITS = 5;

    // Exact t / 85 for any 32-bit t: (t * RECIP_85) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
    localparam int          RECIP_SHIFT = 38;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       stream_end;
    } out_item_t;

    // Front -> converter: what one input byte asks for.
    typedef struct packed {
        logic [31:0]       tuple;
        logic [NDIG_W-1:0] ndig;   // digits to emit (0, 2..5)
        logic              zchar;  // all-zero full group
        logic              post;   // digits follow the newline (tail group)
        logic              nl;     // line break
        logic              fin;    // end marker and final newline
    } cmd_t;

    // Converter -> emitter: digits ready, most significant in slot 0.
    typedef struct packed {
        logic [GROUP_DIGITS-1:0][DIG_W-1:0] dig;
        logic [NDIG_W-1:0]                  ndig;
        logic                               zchar;
        logic                               post;
        logic                               nl;
        logic                               fin;
    } job_t;

endpackage

[hdl/a85_front.sv]
// Front end: group packing, line counting and the command queue.
`timescale 1ns / 1ps

module a85_front #(
    parameter int LINE_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  a85_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output a85_pkg::cmd_t     cmd
);
    import a85_pkg::*;

    localparam int LW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [LW-1:0] POS_LAST = LW'(LINE_BYTES - 1);

    logic [1:0]    fill_reg, fill_next;
    logic [23:0]   bytes_reg, bytes_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    logic  accept, push, pop, full_group;
    logic  [23:0] added;
    cmd_t  new_cmd;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        full_group = (fill_reg == 2'd3);
        case (fill_reg)
            2'd0:    added = {in_item.data_byte, 16'h0000};
            2'd1:    added = {8'h00, in_item.data_byte, 8'h00};
            default: added = {16'h0000, in_item.data_byte};
        endcase

        if (full_group)
        begin
            fill_next  = 2'd0;
            bytes_next = 24'h000000;
        end
        else
        begin
            fill_next  = fill_reg + 2'd1;
            bytes_next = bytes_reg | added;
        end
        pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + LW'(1);
        first_next = 1'b1;

        new_cmd       = '0;
        new_cmd.nl    = first_reg && (pos_reg == '0);
        new_cmd.fin   = in_item.last_byte;
        if (full_group)
        begin
            new_cmd.tuple = {bytes_reg, in_item.data_byte};
            new_cmd.zchar = (new_cmd.tuple == 32'h0);
            new_cmd.ndig  = new_cmd.zchar ? NDIG_W'(0) : NDIG_W'(GROUP_DIGITS);
        end
        else if (in_item.last_byte)
        begin
            // tail group: padded with zeros, fill+1 digits after the newline
            new_cmd.tuple = {bytes_next, 8'h00};
            new_cmd.post  = 1'b1;
            new_cmd.ndig  = NDIG_W'(fill_next) + NDIG_W'(1);
        end
        push = accept && (full_group || new_cmd.nl || in_item.last_byte);

        if (in_item.last_byte)
        begin
            fill_next  = 2'd0;
            bytes_next = 24'h000000;
            pos_next   = '0;
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            bytes_reg  <= 24'h000000;
            pos_reg    <= '0;
            first_reg  <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg  <= fill_next;
                bytes_reg <= bytes_next;
                pos_reg   <= pos_next;
                first_reg <= first_next;
            end
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_cmd;
    end

endmodule

[hdl/a85_conv.sv]
// Base-85 converter: four divisions by 85 through one reciprocal multiplier.
`timescale 1ns / 1ps

module a85_conv (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  a85_pkg::cmd_t cmd,
    output logic          job_valid,
    input  logic          job_ready,
    output a85_pkg::job_t job
);
    import a85_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_SUB, C_DONE} conv_state_t;

    conv_state_t state_reg;
    logic [1:0]  step_reg;
    logic [31:0] t_reg;
    logic [QUOT_W-1:0] p_reg;
    job_t        job_reg;

    logic [63:0]      product;
    logic [DIG_W-1:0] q85_low, rem;
    logic [2:0]       dig_idx;
    logic             load;

    assign product   = {32'h0, t_reg} * {32'h0, RECIP_85};
    // remainder is below 85, so seven bits of the subtraction suffice
    assign q85_low   = p_reg[DIG_W-1:0] * DIG_W'(85);
    assign rem       = t_reg[DIG_W-1:0] - q85_low;
    assign dig_idx   = 3'd4 - {1'b0, step_reg};
    assign cmd_ready = (state_reg == C_IDLE) || (state_reg == C_DONE && job_ready);
    assign load      = cmd_valid && cmd_ready;
    assign job_valid = (state_reg == C_DONE);
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            unique case (state_reg) inside
                C_IDLE, C_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= (cmd.ndig != '0) ? C_MUL : C_DONE;
                        step_reg  <= 2'd0;
                    end
                    else if (state_reg == C_DONE && job_ready)
                        state_reg <= C_IDLE;
                end
                C_MUL:
                    state_reg <= C_SUB;
                C_SUB:
                begin
                    if (step_reg == 2'd3)
                        state_reg <= C_DONE;
                    else
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= C_MUL;
                    end
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_reg         <= cmd.tuple;
            job_reg.dig   <= '0;
            job_reg.ndig  <= cmd.ndig;
            job_reg.zchar <= cmd.zchar;
            job_reg.post  <= cmd.post;
            job_reg.nl    <= cmd.nl;
            job_reg.fin   <= cmd.fin;
        end
        else if (state_reg == C_MUL)
            p_reg <= product[63:RECIP_SHIFT];
        else if (state_reg == C_SUB)
        begin
            job_reg.dig[dig_idx] <= rem;
            t_reg <= {{(32-QUOT_W){1'b0}}, p_reg};
            // after four divisions the quotient is the leading digit
            if (step_reg == 2'd3)
                job_reg.dig[0] <= p_reg[DIG_W-1:0];
        end
    end

endmodule

[hdl/a85_emit.sv]
// Character emitter: walks one job's characters into the output register.
`timescale 1ns / 1ps

module a85_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  a85_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output a85_pkg::out_item_t out_item
);
    import a85_pkg::*;

    logic [GROUP_DIGITS-1:0][DIG_W-1:0] dig_reg, dig_next;
    logic [NDIG_W-1:0] dcnt_reg, dcnt_next;
    logic z_reg, z_next, nl_reg, nl_next, post_reg;
    logic t_reg, t_next, g_reg, g_next, e_reg, e_next;
    logic out_valid_reg;
    out_item_t out_item_reg;

    logic      any, rest, emit;
    out_item_t cur;

    always_comb
    begin
        dig_next  = dig_reg;
        dcnt_next = dcnt_reg;
        z_next    = z_reg;
        nl_next   = nl_reg;
        t_next    = t_reg;
        g_next    = g_reg;
        e_next    = e_reg;
        cur       = '0;

        if (z_reg)
        begin
            cur.out_char = CH_Z;
            z_next       = 1'b0;
        end
        else if (dcnt_reg != '0 && !post_reg)
        begin
            cur.out_char = {1'b0, dig_reg[0]} + CH_BANG;
            dcnt_next    = dcnt_reg - NDIG_W'(1);
            dig_next     = {{DIG_W{1'b0}}, dig_reg[GROUP_DIGITS-1:1]};
        end
        else if (nl_reg)
        begin
            cur.out_char = CH_LF;
            nl_next      = 1'b0;
        end
        else if (dcnt_reg != '0)
        begin
            cur.out_char = {1'b0, dig_reg[0]} + CH_BANG;
            dcnt_next    = dcnt_reg - NDIG_W'(1);
            dig_next     = {{DIG_W{1'b0}}, dig_reg[GROUP_DIGITS-1:1]};
        end
        else if (t_reg)
        begin
            cur.out_char = CH_TILDE;
            t_next       = 1'b0;
        end
        else if (g_reg)
        begin
            cur.out_char = CH_GT;
            g_next       = 1'b0;
        end
        else
        begin
            cur.out_char   = CH_LF;
            cur.stream_end = 1'b1;
            e_next         = 1'b0;
        end

        any  = z_reg || (dcnt_reg != '0) || nl_reg || t_reg || g_reg || e_reg;
        rest = z_next || (dcnt_next != '0) || nl_next || t_next || g_next || e_next;
        cur.run_end = !rest;
        emit = any && (!out_valid_reg || out_ready);
        job_ready = !any || (emit && !rest);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
            z_reg         <= 1'b0;
            nl_reg        <= 1'b0;
            post_reg      <= 1'b0;
            t_reg         <= 1'b0;
            g_reg         <= 1'b0;
            e_reg         <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (job_valid && job_ready)
            begin
                dcnt_reg <= job.ndig;
                z_reg    <= job.zchar;
                nl_reg   <= job.nl;
                post_reg <= job.post;
                t_reg    <= job.fin;
                g_reg    <= job.fin;
                e_reg    <= job.fin;
            end
            else if (emit)
            begin
                dcnt_reg <= dcnt_next;
                z_reg    <= z_next;
                nl_reg   <= nl_next;
                t_reg    <= t_next;
                g_reg    <= g_next;
                e_reg    <= e_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_item_reg <= cur;
        if (job_valid && job_ready)
            dig_reg <= job.dig;
        else if (emit)
            dig_reg <= dig_next;
    end

endmodule

[hdl/ascii85_stream_encoder.sv]
// Top level of the ASCII85 stream encoder: front, converter and emitter.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one raw byte per item,
//   with last_byte set on the final byte of a stream. Output channel
//   (out_valid/out_ready/out_item) gives one ASCII character per item;
//   run_end marks the last character caused by an input byte, stream_end
//   the newline after the closing "~>".
//   Bytes that only add to a group give no characters, save a newline at a line start.
// Structure:
//   Front packs bytes into groups, counts line position and pushes a command
//   into a two-entry queue. The converter turns a group into base-85 digits
//   with four divisions by 85 on one reciprocal multiplier, each a multiply
//   state and a subtract state. The emitter drives one character per cycle
//   into the output register, unless the output stalls, while the converter
//   works on the next group.
// Timing: a full group passes the queue, the converter's states and the
//   output register before its first digit is out. The converter sets the
//   sustained rate and takes the next command only once its job is handed on.
// Reset clears all group and line state. A stall on the output holds the
// output register; the queue fills and in_ready drops only when it is full.
module ascii85_stream_encoder #(
    parameter int LINE_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  a85_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output a85_pkg::out_item_t out_item
);
    import a85_pkg::*;

    logic cmd_valid, cmd_ready, job_valid, job_ready;
    cmd_t cmd;
    job_t job;

    a85_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    a85_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    a85_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // stream end is always the closing newline and ends its byte's run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.stream_end |-> out_item.run_end && out_item.out_char == CH_LF)
    else $error("stream_end without closing newline");

    // commands carry no digits, a tail group, or a full group
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd.ndig == 3'd0 || cmd.ndig == 3'd2 || cmd.ndig == 3'd3
                       || cmd.ndig == 3'd4 || cmd.ndig == 3'd5))
    else $error("bad digit count in command");

    // a zero group gives 'z' only, and tail digits only come with the end mark
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !(job.zchar && job.ndig != 3'd0) && !(job.post && !job.fin))
    else $error("inconsistent job");

endmodule
